// ===== src/tkdp_pkg.sv =====
// Shared types, constants and helpers of the top-k dot-product search core.
package tkdp_pkg;

   // Field widths fixed by the word formats
   localparam int DIMENSION_W  = 13;
   localparam int NEIGHBORS_W  = 5;
   localparam int ELEMENT_W    = 16;
   localparam int RANK_W       = 4;
   localparam int INDEX_W      = 16;
   localparam int SCORE_W      = 32;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 16;
   localparam int SCALE_W      = 14;
   localparam int SCORE_FRAC_W = 30;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_DIMENSION = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEIGHBORS = 4'd1;

   // Register reset values
   localparam logic [DIMENSION_W-1:0] DIMENSION_RESET = 13'd4096;
   localparam logic [NEIGHBORS_W-1:0] NEIGHBORS_RESET = 5'd1;

   // Score scaling and selection floor
   localparam logic [SCALE_W-1:0]        SCORE_SCALE = 14'd10000;
   localparam logic signed [SCORE_W-1:0] SCORE_FLOOR = -32'sd99999;

   // Operation codes of an input word
   localparam logic OP_QUERY     = 1'b0;
   localparam logic OP_CANDIDATE = 1'b1;

   typedef struct packed {
      logic                        op;
      logic signed [ELEMENT_W-1:0] element;
      logic                        final_candidate;
   } req_word_type;

   typedef struct packed {
      logic [RANK_W-1:0]         rank;
      logic [INDEX_W-1:0]        candidate_index;
      logic signed [SCORE_W-1:0] score;
      logic                      last;
   } rsp_word_type;

   // Status of a finished candidate traveling beside its dot product
   typedef struct packed {
      logic               valid;
      logic               run_end;
      logic [INDEX_W-1:0] index;
   } cand_ctl_type;

   // One entry of the best-first list
   typedef struct packed {
      logic                      valid;
      logic signed [SCORE_W-1:0] score;
      logic [INDEX_W-1:0]        index;
   } cell_entry_type;

   // Scored candidate offered to the list
   typedef struct packed {
      logic           run_end;
      cell_entry_type entry;
   } ins_word_type;

   // Commands broadcast to every cell of the list
   typedef struct packed {
      logic insert;
      logic dump;
      logic clear;
   } cell_cmd_type;

   // Accumulator width that holds a full-length dot product exactly
   function automatic int acc_width(input int max_dimension);
      return 32 + $clog2(max_dimension);
   endfunction

endpackage

// ===== src/tkdp_dot_unit.sv =====
// Query store, element position, multiply and dot-product accumulation.
module tkdp_dot_unit #(
   parameter int MAX_DIMENSION = 4096
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    accept,
   input  tkdp_pkg::req_word_type                  req_word,
   input  logic [tkdp_pkg::DIMENSION_W-1:0]        dimension,
   output logic                                    run_closing,
   output logic signed [tkdp_pkg::acc_width(MAX_DIMENSION)-1:0] dot,
   output tkdp_pkg::cand_ctl_type                  dot_ctl
);

   localparam int POS_W  = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
   localparam int ACC_W  = tkdp_pkg::acc_width(MAX_DIMENSION);
   localparam int PROD_W = 2 * tkdp_pkg::ELEMENT_W;

   logic signed [tkdp_pkg::ELEMENT_W-1:0] query_mem [MAX_DIMENSION];

   logic [POS_W:0]   dim_eff;
   logic             vector_end;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic signed [tkdp_pkg::ELEMENT_W-1:0] q_rd_ff;
   logic signed [tkdp_pkg::ELEMENT_W-1:0] s1_elem_ff;
   logic s1_valid_ff, s1_end_ff, s1_final_ff;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic s2_valid_ff, s2_end_ff, s2_final_ff;

   logic signed [ACC_W-1:0] acc_ff, acc_in, acc_sum;
   logic signed [ACC_W-1:0] dot_ff, dot_in;
   tkdp_pkg::cand_ctl_type  ctl_ff, ctl_in;
   logic [tkdp_pkg::INDEX_W-1:0] counter_ff, counter_in;

   // Clamp the configured length into the supported range
   always_comb begin
      if (dimension == '0) begin
         dim_eff = (POS_W+1)'(1);
      end else if (int'(dimension) > MAX_DIMENSION) begin
         dim_eff = (POS_W+1)'(MAX_DIMENSION);
      end else begin
         dim_eff = (POS_W+1)'(dimension);
      end
   end

   assign vector_end  = (({1'b0, pos_ff} + (POS_W+1)'(1)) >= dim_eff);
   assign run_closing = accept && (req_word.op == tkdp_pkg::OP_CANDIDATE) &&
                        vector_end && req_word.final_candidate;

   // Advance the shared position, wrap at the end of a vector
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = vector_end ? '0 : pos_ff + POS_W'(1);
      end
   end

   // Store query words, fetch the matching query word for candidates
   always_ff @(posedge clock) begin
      if (accept && (req_word.op == tkdp_pkg::OP_QUERY)) begin
         query_mem[pos_ff] <= req_word.element;
      end
      if (accept && (req_word.op == tkdp_pkg::OP_CANDIDATE)) begin
         q_rd_ff <= query_mem[pos_ff];
      end
   end

   assign prod_in = q_rd_ff * s1_elem_ff;
   assign acc_sum = acc_ff + ACC_W'(prod_ff);

   // Close a candidate: hand its sum on, number it, restart the sum
   always_comb begin
      acc_in     = acc_ff;
      dot_in     = dot_ff;
      counter_in = counter_ff;
      ctl_in     = '0;
      if (s2_valid_ff) begin
         acc_in = s2_end_ff ? '0 : acc_sum;
         if (s2_end_ff) begin
            dot_in         = acc_sum;
            ctl_in.valid   = 1'b1;
            ctl_in.run_end = s2_final_ff;
            ctl_in.index   = counter_ff;
            // candidate numbers wrap at 2^16 and restart with each run
            counter_in     = s2_final_ff ? '0 : counter_ff + tkdp_pkg::INDEX_W'(1);
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         acc_ff      <= '0;
         ctl_ff      <= '0;
         counter_ff  <= '0;
      end else begin
         pos_ff      <= pos_in;
         s1_valid_ff <= accept && (req_word.op == tkdp_pkg::OP_CANDIDATE);
         s2_valid_ff <= s1_valid_ff;
         acc_ff      <= acc_in;
         ctl_ff      <= ctl_in;
         counter_ff  <= counter_in;
      end
   end

   // Advance the payload stages
   always_ff @(posedge clock) begin
      s1_elem_ff  <= req_word.element;
      s1_end_ff   <= vector_end;
      s1_final_ff <= req_word.final_candidate;
      prod_ff     <= prod_in;
      s2_end_ff   <= s1_end_ff;
      s2_final_ff <= s1_final_ff;
      dot_ff      <= dot_in;
   end

   assign dot     = dot_ff;
   assign dot_ctl = ctl_ff;

endmodule

// ===== src/tkdp_score_unit.sv =====
// Scales a dot product by 10000/2^30, truncates toward zero, saturates to 32 bits.
module tkdp_score_unit #(
   parameter int ACC_W = 44
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic signed [ACC_W-1:0] dot,
   input  tkdp_pkg::cand_ctl_type  dot_ctl,
   output tkdp_pkg::ins_word_type  ins_word
);

   localparam int HI_W = ACC_W / 2;
   localparam int LO_W = ACC_W - HI_W;
   localparam int SC_W = ACC_W + tkdp_pkg::SCALE_W + 1;

   localparam logic signed [SC_W-1:0] BIAS   = SC_W'(64'sh3FFF_FFFF);
   localparam logic signed [SC_W-1:0] SAT_HI = SC_W'(64'sh7FFF_FFFF);
   localparam logic signed [SC_W-1:0] SAT_LO = ~SAT_HI;

   logic signed [HI_W+tkdp_pkg::SCALE_W:0] hi_prod_ff, hi_prod_in;
   logic [LO_W+tkdp_pkg::SCALE_W-1:0]      lo_prod_ff, lo_prod_in;
   logic signed [SC_W-1:0]                 full_ff, full_in;
   logic signed [SC_W-1:0]                 biased, scaled;
   logic signed [tkdp_pkg::SCORE_W-1:0]    score;
   tkdp_pkg::cand_ctl_type                 ctl_a_ff, ctl_b_ff;
   tkdp_pkg::ins_word_type                 ins_ff, ins_in;

   // Split the product into two narrow multiplies
   assign hi_prod_in = $signed(dot[ACC_W-1:LO_W]) * $signed({1'b0, tkdp_pkg::SCORE_SCALE});
   assign lo_prod_in = dot[LO_W-1:0] * tkdp_pkg::SCORE_SCALE;

   // Recombine the partial products
   assign full_in = (SC_W'(hi_prod_ff) <<< LO_W) + $signed(SC_W'(lo_prod_ff));

   // Round negative values toward zero before dropping the fraction
   always_comb begin
      biased = full_ff;
      if (full_ff[SC_W-1]) begin
         biased = full_ff + BIAS;
      end
      scaled = biased >>> tkdp_pkg::SCORE_FRAC_W;
      if (scaled > SAT_HI) begin
         score = 32'sh7FFF_FFFF;
      end else if (scaled < SAT_LO) begin
         score = -32'sh8000_0000;
      end else begin
         score = scaled[tkdp_pkg::SCORE_W-1:0];
      end
   end

   // Drop scores at or below the floor
   always_comb begin
      ins_in              = '0;
      ins_in.run_end      = ctl_b_ff.valid && ctl_b_ff.run_end;
      ins_in.entry.valid  = ctl_b_ff.valid && (score > tkdp_pkg::SCORE_FLOOR);
      ins_in.entry.score  = score;
      ins_in.entry.index  = ctl_b_ff.index;
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ins_ff   <= '0;
      end else begin
         ctl_a_ff <= dot_ctl;
         ctl_b_ff <= ctl_a_ff;
         ins_ff   <= ins_in;
      end
   end

   // Advance the arithmetic stages
   always_ff @(posedge clock) begin
      hi_prod_ff <= hi_prod_in;
      lo_prod_ff <= lo_prod_in;
      full_ff    <= full_in;
   end

   assign ins_word = ins_ff;

endmodule

// ===== src/tkdp_cell.sv =====
// One entry of the sorted best-first list: compare, shift down on insert, shift up on dump.
module tkdp_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  tkdp_pkg::cell_cmd_type   cmd,
   input  tkdp_pkg::cell_entry_type new_entry,
   input  tkdp_pkg::cell_entry_type prev_entry,
   input  logic                     prev_take,
   input  tkdp_pkg::cell_entry_type next_entry,
   output tkdp_pkg::cell_entry_type entry,
   output logic                     take
);

   tkdp_pkg::cell_entry_type entry_ff, entry_in;

   // A free cell or a strictly lower score gives way; equal scores keep the earlier entry
   assign take = !entry_ff.valid || (new_entry.score > entry_ff.score);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.clear) begin
         entry_in.valid = 1'b0;
      end else if (cmd.dump) begin
         entry_in = next_entry;
      end else if (cmd.insert && take) begin
         entry_in = prev_take ? prev_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== src/top_k_dot_product_search_core.sv =====
// Top-k dot-product search core: multiply-accumulate front end, scoring pipeline, list of cells.
// Throughput: one vector word per cycle while busy is low, set by the single query memory port.
// The final candidate's last word runs through the dot and scoring registers into the list;
// results then strobe one per cycle, and busy falls with the last one or on an empty flush.
// The receiver cannot stall; results are never held back. Reset is synchronous and clears
// all control state at once (dimension 4096, neighbors_wanted 1); there is no clearing pass.
module top_k_dot_product_search_core #(
   parameter int MAX_DIMENSION = 4096,
   parameter int MAX_NEIGHBORS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  tkdp_pkg::req_word_type             req_word,
   output logic                               rsp_valid,
   output tkdp_pkg::rsp_word_type             rsp_word,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tkdp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tkdp_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int ACC_W = tkdp_pkg::acc_width(MAX_DIMENSION);
   localparam int NB_W  = $clog2(MAX_NEIGHBORS + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   logic [tkdp_pkg::DIMENSION_W-1:0] dimension_ff, dimension_in;
   logic [tkdp_pkg::NEIGHBORS_W-1:0] neighbors_ff, neighbors_in;

   logic accept, run_closing;
   logic busy_ff, busy_in;
   logic [0:0] state_ff, state_in;
   logic [NB_W-1:0] count_ff, count_in, k_eff;
   logic emit, last_emit, dump_done;

   logic signed [ACC_W-1:0] dot;
   tkdp_pkg::cand_ctl_type  dot_ctl;
   tkdp_pkg::ins_word_type  ins_word;
   tkdp_pkg::cell_cmd_type  cmd;

   tkdp_pkg::cell_entry_type cell_q [MAX_NEIGHBORS+1];
   logic [MAX_NEIGHBORS:0]   take_vec;

   logic                   rsp_valid_ff;
   tkdp_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // Configuration registers: always ready, unknown indexes ignored
   assign csr_ready = 1'b1;

   always_comb begin
      dimension_in = dimension_ff;
      neighbors_in = neighbors_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tkdp_pkg::CSR_DIMENSION: dimension_in = csr_data[tkdp_pkg::DIMENSION_W-1:0];
            tkdp_pkg::CSR_NEIGHBORS: neighbors_in = csr_data[tkdp_pkg::NEIGHBORS_W-1:0];
            default: ;
         endcase
      end
   end

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   tkdp_dot_unit #(
      .MAX_DIMENSION(MAX_DIMENSION)
   ) u_dot (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_word    (req_word),
      .dimension   (dimension_ff),
      .run_closing (run_closing),
      .dot         (dot),
      .dot_ctl     (dot_ctl)
   );

   tkdp_score_unit #(
      .ACC_W(ACC_W)
   ) u_score (
      .clock    (clock),
      .reset    (reset),
      .dot      (dot),
      .dot_ctl  (dot_ctl),
      .ins_word (ins_word)
   );

   // Build the list as a row of cells; the slot past the tail is always empty
   assign take_vec[0]           = 1'b0;
   assign cell_q[MAX_NEIGHBORS] = '0;

   for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
      tkdp_pkg::cell_entry_type prev_entry;
      if (i == 0) begin : g_head
         assign prev_entry = ins_word.entry;
      end else begin : g_body
         assign prev_entry = cell_q[i-1];
      end
      tkdp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .new_entry  (ins_word.entry),
         .prev_entry (prev_entry),
         .prev_take  (take_vec[i]),
         .next_entry (cell_q[i+1]),
         .entry      (cell_q[i]),
         .take       (take_vec[i+1])
      );
   end

   // Emit from the head of the list while entries remain and the count allows
   always_comb begin
      if (int'(neighbors_ff) > MAX_NEIGHBORS) begin
         k_eff = NB_W'(MAX_NEIGHBORS);
      end else begin
         k_eff = NB_W'(neighbors_ff);
      end
   end

   assign emit      = (state_ff == ST_DUMP) && cell_q[0].valid && (count_ff < k_eff);
   assign last_emit = ((count_ff + NB_W'(1)) == k_eff) || !cell_q[1].valid;
   assign dump_done = (state_ff == ST_DUMP) && (!emit || last_emit);

   always_comb begin
      cmd.insert = ins_word.entry.valid;
      cmd.dump   = emit;
      cmd.clear  = dump_done;
   end

   // Sequence the end of a run
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ins_word.run_end) begin
               state_in = ST_DUMP;
            end
         end
         ST_DUMP: begin
            if (dump_done) begin
               state_in = ST_IDLE;
               count_in = '0;
            end else begin
               count_in = count_ff + NB_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold off new words from the final candidate until the list is flushed
   always_comb begin
      busy_in = busy_ff;
      if (run_closing) begin
         busy_in = 1'b1;
      end else if (dump_done) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_word_in.rank            = tkdp_pkg::RANK_W'(count_ff);
      rsp_word_in.candidate_index = cell_q[0].index;
      rsp_word_in.score           = cell_q[0].score;
      rsp_word_in.last            = last_emit;
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff <= tkdp_pkg::DIMENSION_RESET;
         neighbors_ff <= tkdp_pkg::NEIGHBORS_RESET;
         busy_ff      <= 1'b0;
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dimension_ff <= dimension_in;
         neighbors_ff <= neighbors_in;
         busy_ff      <= busy_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= emit;
      end
   end

   // Register the result word
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // The list stays a sorted, gap-free prefix
   for (genvar i = 0; i < MAX_NEIGHBORS - 1; i++) begin : g_sorted_chk
      assert property (@(posedge clock) disable iff (reset)
         cell_q[i+1].valid |-> (cell_q[i].valid && (cell_q[i].score >= cell_q[i+1].score)))
         else $error("best-first list out of order");
   end

   // Flushing only happens with the input side held off
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |-> busy_ff)
      else $error("list flushed while input is open");

   // Ranks of one run come back to back, one apart
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.last) |=>
         (rsp_valid_ff && (rsp_word_ff.rank == $past(rsp_word_ff.rank) + 4'd1)))
      else $error("result sequence broken");

   // Nothing follows the final result of a run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.last) |=> !rsp_valid_ff)
      else $error("result after final word");

endmodule
